>>> rtl/rv32i_decode_execute_assert.svh
// Assertion macros shared by the decode and execute RTL.
`ifndef RV32I_DECODE_EXECUTE_ASSERT_SVH
`define RV32I_DECODE_EXECUTE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RVDE_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("decode/execute assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RVDE_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("decode/execute assertion failed");

`endif

>>> rtl/rvde_pkg.sv
// Types and encoding constants for the RV32I decode and execute block.
package rvde_pkg;

   localparam int XLEN = 32;

   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // ALU funct3 codes.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // Load and store funct3 codes.
   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   // Branch funct3 codes.
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_JALR = 3'd0;

   typedef enum logic [3:0] {
      MEM_NONE = 4'd0,
      MEM_LB   = 4'd1,
      MEM_LH   = 4'd2,
      MEM_LW   = 4'd3,
      MEM_LBU  = 4'd4,
      MEM_LHU  = 4'd5,
      MEM_SB   = 4'd6,
      MEM_SH   = 4'd7,
      MEM_SW   = 4'd8
   } mem_kind_type;

   typedef struct packed {
      logic [XLEN-1:0] result;
      logic            write_enable;
      logic [4:0]      dest_reg;
      logic            taken;
      logic [XLEN-1:0] target;
      mem_kind_type    mem_kind;
      logic [XLEN-1:0] store_data;
      logic            illegal;
   } exec_result_type;

endpackage

>>> rtl/rvde_if.sv
// Valid/ready channel interfaces for instruction requests and execute responses.
interface rvde_req_if
   import rvde_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [XLEN-1:0] instruction;
   logic [XLEN-1:0] pc;
   logic [XLEN-1:0] rs1_value;
   logic [XLEN-1:0] rs2_value;

   modport source (output valid, output instruction, output pc, output rs1_value,
                   output rs2_value, input ready);
   modport sink (input valid, input instruction, input pc, input rs1_value,
                 input rs2_value, output ready);
endinterface

interface rvde_rsp_if
   import rvde_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [XLEN-1:0] result;
   logic            write_enable;
   logic [4:0]      dest_reg;
   logic            taken;
   logic [XLEN-1:0] target;
   logic [3:0]      mem_kind;
   logic [XLEN-1:0] store_data;
   logic            illegal;

   modport source (output valid, output result, output write_enable, output dest_reg,
                   output taken, output target, output mem_kind, output store_data,
                   output illegal, input ready);
   modport sink (input valid, input result, input write_enable, input dest_reg,
                 input taken, input target, input mem_kind, input store_data,
                 input illegal, output ready);
endinterface

>>> rtl/rv32i_decode_execute.sv
// RV32I decode and execute: a request register feeds the decode and ALU logic, whose output
// lands in a response register. Throughput is one instruction per cycle while rsp ready is
// high; each stage loads when it is empty or when its contents are taken onward.
// A full response register stalls the request register only while rsp ready is low.
// Synchronous active-high reset empties both stages; payload registers are not reset.
`include "rv32i_decode_execute_assert.svh"

module rv32i_decode_execute
   import rvde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rvde_req_if.sink    req_if,
   rvde_rsp_if.source  rsp_if
);

   logic            in_valid_ff, in_valid_in;
   logic [XLEN-1:0] ins_ff, pc_ff, rs1_ff, rs2_ff;
   logic            out_valid_ff, out_valid_in;
   exec_result_type out_ff, exec_res_in;

   logic out_adv;
   logic in_ready;

   assign out_adv  = !out_valid_ff || rsp_if.ready;
   assign in_ready = !in_valid_ff || out_adv;
   assign req_if.ready = in_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_ready) begin
         in_valid_in = req_if.valid;
      end
      out_valid_in = out_valid_ff;
      if (out_adv) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ins_ff <= req_if.instruction;
         pc_ff  <= req_if.pc;
         rs1_ff <= req_if.rs1_value;
         rs2_ff <= req_if.rs2_value;
      end
      if (out_adv) begin
         out_ff <= exec_res_in;
      end
   end

   // Instruction fields and immediates.
   logic [6:0]      opc, f7;
   logic [4:0]      rd;
   logic [2:0]      f3;
   logic [XLEN-1:0] immi, imms, immb, immu, immj;

   assign opc  = ins_ff[6:0];
   assign rd   = ins_ff[11:7];
   assign f3   = ins_ff[14:12];
   assign f7   = ins_ff[31:25];
   assign immi = {{20{ins_ff[31]}}, ins_ff[31:20]};
   assign imms = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
   assign immb = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
   assign immu = {ins_ff[31:12], 12'b0};
   assign immj = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20], ins_ff[30:21],
                  1'b0};

   // ALU shared by register and immediate forms.
   logic [XLEN-1:0] alu_b, alu_res;
   logic [4:0]      shamt;
   logic            alu_alt;
   logic            lt_s, lt_u;

   assign alu_b   = (opc == OPC_OP) ? rs2_ff : immi;
   assign shamt   = alu_b[4:0];
   assign alu_alt = (f7 == F7_ALT) &&
                    ((opc == OPC_OP) ? (f3 inside {F3_ADD, F3_SR}) : (f3 == F3_SR));
   assign lt_s    = $signed(rs1_ff) < $signed(rs2_ff);
   assign lt_u    = rs1_ff < rs2_ff;

   always_comb begin
      case (f3)
         F3_ADD:  alu_res = alu_alt ? rs1_ff - alu_b : rs1_ff + alu_b;
         F3_SLL:  alu_res = rs1_ff << shamt;
         F3_SLT:  alu_res = {{(XLEN-1){1'b0}}, $signed(rs1_ff) < $signed(alu_b)};
         F3_SLTU: alu_res = {{(XLEN-1){1'b0}}, rs1_ff < alu_b};
         F3_XOR:  alu_res = rs1_ff ^ alu_b;
         F3_SR:   alu_res = alu_alt ? $unsigned($signed(rs1_ff) >>> shamt) : rs1_ff >> shamt;
         F3_OR:   alu_res = rs1_ff | alu_b;
         F3_AND:  alu_res = rs1_ff & alu_b;
         default: alu_res = rs1_ff & alu_b;
      endcase
   end

   always_comb begin
      logic [XLEN-1:0] res, tgt, sdata;
      logic            wr, tk, ok;
      mem_kind_type    kind;

      res   = '0;
      tgt   = '0;
      sdata = '0;
      wr    = 1'b0;
      tk    = 1'b0;
      ok    = 1'b1;
      kind  = MEM_NONE;

      case (opc)
         OPC_OP: begin
            ok  = (f7 == F7_BASE) || ((f7 == F7_ALT) && (f3 inside {F3_ADD, F3_SR}));
            res = alu_res;
            wr  = 1'b1;
         end
         OPC_OPIMM: begin
            if (f3 == F3_SLL) begin
               ok = (f7 == F7_BASE);
            end else if (f3 == F3_SR) begin
               ok = (f7 == F7_BASE) || (f7 == F7_ALT);
            end
            res = alu_res;
            wr  = 1'b1;
         end
         OPC_LOAD: begin
            case (f3)
               F3_B:    kind = MEM_LB;
               F3_H:    kind = MEM_LH;
               F3_W:    kind = MEM_LW;
               F3_BU:   kind = MEM_LBU;
               F3_HU:   kind = MEM_LHU;
               default: ok = 1'b0;
            endcase
            res = rs1_ff + immi;
            wr  = 1'b1;
         end
         OPC_STORE: begin
            case (f3)
               F3_B:    kind = MEM_SB;
               F3_H:    kind = MEM_SH;
               F3_W:    kind = MEM_SW;
               default: ok = 1'b0;
            endcase
            res   = rs1_ff + imms;
            sdata = rs2_ff;
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  tk = (rs1_ff == rs2_ff);
               F3_BNE:  tk = (rs1_ff != rs2_ff);
               F3_BLT:  tk = lt_s;
               F3_BGE:  tk = !lt_s;
               F3_BLTU: tk = lt_u;
               F3_BGEU: tk = !lt_u;
               default: ok = 1'b0;
            endcase
            tgt = pc_ff + immb;
         end
         OPC_JAL: begin
            res = pc_ff + XLEN'(4);
            tgt = pc_ff + immj;
            tk  = 1'b1;
            wr  = 1'b1;
         end
         OPC_JALR: begin
            ok  = (f3 == F3_JALR);
            res = pc_ff + XLEN'(4);
            tgt = (rs1_ff + immi) & ~XLEN'(1);
            tk  = 1'b1;
            wr  = 1'b1;
         end
         OPC_LUI: begin
            res = immu;
            wr  = 1'b1;
         end
         OPC_AUIPC: begin
            res = pc_ff + immu;
            wr  = 1'b1;
         end
         default: ok = 1'b0;
      endcase

      // An unrecognized word retires as a no-op with only the illegal flag set.
      if (ok) begin
         exec_res_in.result       = res;
         exec_res_in.write_enable = wr && (rd != 5'd0);
         exec_res_in.dest_reg     = wr ? rd : 5'd0;
         exec_res_in.taken        = tk;
         exec_res_in.target       = tgt;
         exec_res_in.mem_kind     = kind;
         exec_res_in.store_data   = sdata;
         exec_res_in.illegal      = 1'b0;
      end else begin
         exec_res_in          = '0;
         exec_res_in.mem_kind = MEM_NONE;
         exec_res_in.illegal  = 1'b1;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result       = out_ff.result;
   assign rsp_if.write_enable = out_ff.write_enable;
   assign rsp_if.dest_reg     = out_ff.dest_reg;
   assign rsp_if.taken        = out_ff.taken;
   assign rsp_if.target       = out_ff.target;
   assign rsp_if.mem_kind     = out_ff.mem_kind;
   assign rsp_if.store_data   = out_ff.store_data;
   assign rsp_if.illegal      = out_ff.illegal;

   `RVDE_ASSERT_NEXT(a_stage_moves, clock, reset, in_valid_ff && out_adv, out_valid_ff)
   `RVDE_ASSERT_IMPLY(a_illegal_quiet, clock, reset, out_valid_ff && out_ff.illegal,
      (out_ff.result == '0) && !out_ff.write_enable && (out_ff.dest_reg == 5'd0) &&
      !out_ff.taken && (out_ff.target == '0) && (out_ff.store_data == '0))
   `RVDE_ASSERT_IMPLY(a_we_needs_rd, clock, reset, out_valid_ff && out_ff.write_enable,
      (out_ff.dest_reg != 5'd0) && !out_ff.illegal)
   `RVDE_ASSERT_IMPLY(a_store_no_write, clock, reset,
      out_valid_ff && ((out_ff.mem_kind == MEM_SB) || (out_ff.mem_kind == MEM_SH) ||
      (out_ff.mem_kind == MEM_SW)),
      !out_ff.write_enable && (out_ff.dest_reg == 5'd0))

endmodule
